// ----- rtl/core/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, constants and arithmetic helpers of the scalar color map.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned DEF_SAMPLE_WIDTH = 16;
  localparam int unsigned DEF_COLOR_BITS   = 8;
  localparam int unsigned FRAC_BITS        = 16;
  localparam int unsigned ACC_W            = 28;
  localparam int unsigned HUE_W            = 9;
  localparam int unsigned RGB_W            = 24;
  localparam int unsigned CFG_AW           = 3;

  localparam logic [FRAC_BITS:0] ONE_Q16  = 17'h10000;
  localparam logic [FRAC_BITS:0] GREY_Q16 = 17'd59638;
  // ceil(2^27 / 15): hue * 2^16 / 60 as a reciprocal product
  localparam logic [23:0] HUE_RECIP = 24'd8947849;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [FRAC_BITS:0] q16_t;

  typedef enum logic [2:0] {
    MODE_GREY      = 3'd0,
    MODE_JET       = 3'd1,
    MODE_RAINBOW   = 3'd2,
    MODE_TURBO     = 3'd3,
    MODE_HUE       = 3'd4,
    MODE_DIVERGENT = 3'd5
  } map_mode_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MODE       = 3'd0,
    CFG_MIN        = 3'd1,
    CFG_MAX        = 3'd2,
    CFG_MEDIAN     = 3'd3,
    CFG_BASE_HUE   = 3'd4,
    CFG_LOW_COLOR  = 3'd5,
    CFG_HIGH_COLOR = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    map_mode_e mode;
    logic      above;
    logic      byp;
    logic      byp_one;
  } scm_tag_t;

  localparam acc_t TURBO_COEF [3][6] = '{
    '{28'sd8895, 28'sd302474, -28'sd2795787, 28'sd8659343, -28'sd10023233, 28'sd3885392},
    '{28'sd5990, 28'sd143798, 28'sd317389, -28'sd929630, 28'sd280317, 28'sd185438},
    '{28'sd6991, 28'sd828503, -28'sd3970305, 28'sd7232734, -28'sd5891890, 28'sd1792295}
  };

  // product with a Q16 fraction, rounded half away from zero
  function automatic acc_t mul_round(acc_t a, q16_t t);
    logic                       neg;
    logic [ACC_W-1:0]           mag;
    logic [ACC_W+FRAC_BITS:0]   prod;
    logic [ACC_W-1:0]           r;
    neg  = a[ACC_W-1];
    mag  = neg ? ACC_W'(-a) : ACC_W'(a);
    prod = (ACC_W+FRAC_BITS+1)'(mag) * (ACC_W+FRAC_BITS+1)'(t)
           + (ACC_W+FRAC_BITS+1)'(32768);
    r    = prod[ACC_W+FRAC_BITS-1:FRAC_BITS];
    return neg ? -acc_t'(r) : acc_t'(r);
  endfunction

  function automatic acc_t turbo_step(acc_t acc, q16_t t, int unsigned ch, int unsigned j);
    return TURBO_COEF[ch][j] + mul_round(acc, t);
  endfunction

  // HSV sector mix; element 0 is red
  function automatic logic [2:0][FRAC_BITS+1:0] hsv_mix(logic [3:0] sector, q16_t ch,
                                                      q16_t xx, q16_t m);
    logic [FRAC_BITS+1:0] c;
    logic [FRAC_BITS+1:0] x;
    logic [FRAC_BITS+1:0] z;
    logic [2:0][FRAC_BITS+1:0] o;
    c = {1'b0, ch} + {1'b0, m};
    x = {1'b0, xx} + {1'b0, m};
    z = {1'b0, m};
    case (sector)
      4'd0: begin o[0] = c; o[1] = x; o[2] = z; end
      4'd1: begin o[0] = x; o[1] = c; o[2] = z; end
      4'd2: begin o[0] = z; o[1] = c; o[2] = x; end
      4'd3: begin o[0] = z; o[1] = x; o[2] = c; end
      4'd4: begin o[0] = x; o[1] = z; o[2] = c; end
      default: begin o[0] = c; o[1] = z; o[2] = x; end
    endcase
    return o;
  endfunction

endpackage

// ----- rtl/core/scm_div.sv -----
// ----------------------------------------------------------------------------
// scm_div
// Pipelined restoring divider: floor(num * 2^16 / den), one quotient bit
// per stage, for num < den.
// ----------------------------------------------------------------------------
module scm_div import scm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [SAMPLE_WIDTH-1:0] num_i,
  input  logic [SAMPLE_WIDTH-1:0] den_i,
  input  scm_tag_t                tag_i,
  output logic                    valid_o,
  output logic [FRAC_BITS-1:0]    quot_o,
  output scm_tag_t                tag_o
);

  logic [SAMPLE_WIDTH-1:0] rem_q  [FRAC_BITS+1];
  logic [SAMPLE_WIDTH-1:0] den_q  [FRAC_BITS+1];
  logic [FRAC_BITS-1:0]    quot_q [FRAC_BITS+1];
  scm_tag_t                tag_q  [FRAC_BITS+1];
  logic [FRAC_BITS:0]      vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FRAC_BITS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      den_q[0]  <= den_i;
      quot_q[0] <= '0;
      tag_q[0]  <= tag_i;
    end
  end

  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [SAMPLE_WIDTH:0] sh;
    logic [SAMPLE_WIDTH:0] diff;
    logic                  ge;
    assign sh   = {rem_q[k-1], 1'b0};
    assign diff = sh - {1'b0, den_q[k-1]};
    assign ge   = sh >= {1'b0, den_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[SAMPLE_WIDTH-1:0] : sh[SAMPLE_WIDTH-1:0];
        den_q[k]  <= den_q[k-1];
        quot_q[k] <= {quot_q[k-1][FRAC_BITS-2:0], ge};
        tag_q[k]  <= tag_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[FRAC_BITS];
  assign quot_o  = quot_q[FRAC_BITS];
  assign tag_o   = tag_q[FRAC_BITS];

endmodule

// ----- rtl/core/scalar_to_color_map_top.sv -----
// ----------------------------------------------------------------------------
// scalar_to_color_map_top
// Maps a signed scalar sample to an RGB color in one of six color maps.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the output is not stalled; it passes
// through the 16-stage divider that normalizes the sample, followed
// by the five-step turbo polynomial and the output scaling. Any stall on the
// output holds the whole pipeline. Configuration registers are read at the
// stages that use them, so a write can also affect samples in flight.
module scalar_to_color_map_top import scm_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int unsigned COLOR_BITS   = DEF_COLOR_BITS,
  localparam int unsigned IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((3 * COLOR_BITS + 7) / 8) * 8,
  localparam int unsigned CFG_W = (SAMPLE_WIDTH > RGB_W) ? SAMPLE_WIDTH : RGB_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // scalar
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // red, green, blue
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam logic [COLOR_BITS-1:0] MAXC = {COLOR_BITS{1'b1}};

  map_mode_e              mode_q;
  logic signed [SW-1:0]   min_q, max_q, med_q;
  logic [HUE_W-1:0]       hue_q;
  logic [RGB_W-1:0]       low_q, high_q;
  logic [19:0]            hue_hs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GREY;
      min_q  <= {1'b1, {(SW-1){1'b0}}};
      max_q  <= {1'b0, {(SW-1){1'b1}}};
      med_q  <= '0;
      hue_q  <= '0;
      low_q  <= 24'h0000FF;
      high_q <= 24'hFF0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_MODE:       mode_q <= map_mode_e'(cfg_wdata_i[2:0]);
        CFG_MIN:        min_q  <= cfg_wdata_i[SW-1:0];
        CFG_MAX:        max_q  <= cfg_wdata_i[SW-1:0];
        CFG_MEDIAN:     med_q  <= cfg_wdata_i[SW-1:0];
        CFG_BASE_HUE:   hue_q  <= cfg_wdata_i[HUE_W-1:0];
        CFG_LOW_COLOR:  low_q  <= cfg_wdata_i[RGB_W-1:0];
        CFG_HIGH_COLOR: high_q <= cfg_wdata_i[RGB_W-1:0];
        default: ;
      endcase
    end
  end

  logic [32:0] hue_prod;
  assign hue_prod = 33'(hue_q) * 33'(HUE_RECIP);

  always_ff @(posedge clk_i) begin
    hue_hs_q <= hue_prod[32:13];
  end

  logic en;
  logic out_v_q;
  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  // input stage
  logic                 p0_v_q, p0_below_q;
  logic signed [SW-1:0] p0_s_q;
  map_mode_e            p0_mode_q;
  logic signed [SW-1:0] s_in;
  assign s_in = s_axis_tdata[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_s_q     <= s_in;
      p0_below_q <= s_in <= med_q;
      p0_mode_q  <= mode_q;
    end
  end

  // bounds and differences
  logic                 p1_v_q, p1_above_q;
  logic signed [SW:0]   p1_a_q, p1_b_q;
  map_mode_e            p1_mode_q;
  logic signed [SW-1:0] lo_sel, hi_sel;
  logic                 div_mode;

  assign div_mode = p0_mode_q == MODE_DIVERGENT;
  assign lo_sel   = (div_mode && !p0_below_q) ? med_q : min_q;
  assign hi_sel   = (div_mode && p0_below_q) ? med_q : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_a_q     <= (SW+1)'(p0_s_q) - (SW+1)'(lo_sel);
      p1_b_q     <= (SW+1)'(hi_sel) - (SW+1)'(lo_sel);
      p1_mode_q  <= p0_mode_q;
      p1_above_q <= div_mode && !p0_below_q;
    end
  end

  // divide
  logic                 b_pos, a_le0, a_ge_b;
  scm_tag_t             div_tag_in, div_tag_out;
  logic                 div_v;
  logic [FRAC_BITS-1:0] div_quot;

  assign b_pos  = p1_b_q > 0;
  assign a_le0  = p1_a_q <= 0;
  assign a_ge_b = p1_a_q >= p1_b_q;

  assign div_tag_in.mode    = p1_mode_q;
  assign div_tag_in.above   = p1_above_q;
  assign div_tag_in.byp     = !b_pos || a_le0 || a_ge_b;
  assign div_tag_in.byp_one = b_pos ? (!a_le0 && a_ge_b) : p1_above_q;

  scm_div #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p1_v_q),
    .num_i   (p1_a_q[SW-1:0]),
    .den_i   (p1_b_q[SW-1:0]),
    .tag_i   (div_tag_in),
    .valid_o (div_v),
    .quot_o  (div_quot),
    .tag_o   (div_tag_out)
  );

  // e0: fraction and grey weight
  logic      e0_v_q, e0_above_q;
  q16_t      e0_t_q, e0_u_q;
  map_mode_e e0_mode_q;
  q16_t      t_full;

  assign t_full = div_tag_out.byp ? (div_tag_out.byp_one ? ONE_Q16 : '0)
                                  : {1'b0, div_quot};

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_t_q     <= t_full;
      e0_u_q     <= div_tag_out.above ? ONE_Q16 - t_full : t_full;
      e0_mode_q  <= div_tag_out.mode;
      e0_above_q <= div_tag_out.above;
    end
  end

  // e1: direct maps, first products
  function automatic acc_t jet_ch(q16_t t, logic [17:0] off);
    logic signed [20:0] d;
    d = $signed({2'b00, t, 2'b00}) - $signed({3'b000, off});
    if (d < 0) begin
      d = -d;
    end
    return acc_t'(21'sd98304 - d);
  endfunction

  logic                      e1_v_q;
  map_mode_e                 e1_mode_q;
  acc_t                      e1_c_q [3];
  acc_t                      e1_acc_q [3];
  q16_t                      e1_t_q, e1_ch_q, e1_xh_q;
  logic [3:0]                e1_sec_q;
  logic [33:0]               e1_ew_q [3];
  logic [33:0]               e1_gw_q;

  logic [20:0]               rb_hs9;
  logic [19:0]               rb_hs;
  q16_t                      rb_om, rb_x, hue_x;
  logic [2:0][FRAC_BITS+1:0] rb_mix;
  logic [33:0]               sq_prod;
  logic [RGB_W-1:0]          col;
  logic [FRAC_BITS:0]        e_exp [3];
  acc_t                      e1_c_d [3];

  assign rb_om  = ONE_Q16 - e0_t_q;
  assign rb_hs9 = {1'b0, rb_om, 3'b000} + {4'b0000, rb_om};
  assign rb_hs  = rb_hs9[20:1];
  assign rb_x   = rb_hs[16] ? ONE_Q16 - {1'b0, rb_hs[15:0]} : {1'b0, rb_hs[15:0]};
  assign rb_mix = hsv_mix(rb_hs[19:16], ONE_Q16, rb_x, '0);
  assign hue_x  = hue_hs_q[16] ? ONE_Q16 - {1'b0, hue_hs_q[15:0]}
                               : {1'b0, hue_hs_q[15:0]};
  assign sq_prod = 34'(e0_t_q) * 34'(e0_t_q);
  assign col     = e0_above_q ? high_q : low_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e_exp[k] = {1'b0, col[16-8*k +: 8], col[16-8*k +: 8]} + 17'(col[23-8*k]);
    end
    for (int k = 0; k < 3; k++) begin
      e1_c_d[k] = '0;
    end
    case (e0_mode_q)
      MODE_GREY: begin
        for (int k = 0; k < 3; k++) begin
          e1_c_d[k] = acc_t'(e0_t_q);
        end
      end
      MODE_JET: begin
        e1_c_d[0] = jet_ch(e0_t_q, 18'd196608);
        e1_c_d[1] = jet_ch(e0_t_q, 18'd131072);
        e1_c_d[2] = jet_ch(e0_t_q, 18'd65536);
      end
      MODE_RAINBOW: begin
        for (int k = 0; k < 3; k++) begin
          e1_c_d[k] = acc_t'(rb_mix[k]);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_mode_q <= e0_mode_q;
      e1_t_q    <= e0_t_q;
      e1_ch_q   <= sq_prod[32:16];
      e1_xh_q   <= hue_x;
      e1_sec_q  <= hue_hs_q[19:16];
      e1_gw_q   <= 34'(GREY_Q16) * 34'(e0_u_q);
      for (int k = 0; k < 3; k++) begin
        e1_c_q[k]   <= e1_c_d[k];
        e1_acc_q[k] <= turbo_step(TURBO_COEF[k][5], e0_t_q, k, 4);
        e1_ew_q[k]  <= 34'(e_exp[k]) * 34'(ONE_Q16 - e0_u_q);
      end
    end
  end

  // e2: divergent blend, hue products
  logic        e2_v_q;
  map_mode_e   e2_mode_q;
  acc_t        e2_c_q [3];
  acc_t        e2_acc_q [3];
  q16_t        e2_t_q, e2_ch_q, e2_xx_q, e2_m_q;
  logic [3:0]  e2_sec_q;
  logic [33:0] xx_prod;
  logic [34:0] blend [3];

  assign xx_prod = 34'(e1_ch_q) * 34'(e1_xh_q);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      blend[k] = 35'(e1_ew_q[k]) + 35'(e1_gw_q) + 35'(32768);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_mode_q <= e1_mode_q;
      e2_t_q    <= e1_t_q;
      e2_ch_q   <= e1_ch_q;
      e2_xx_q   <= xx_prod[32:16];
      e2_m_q    <= e1_t_q - e1_ch_q;
      e2_sec_q  <= e1_sec_q;
      for (int k = 0; k < 3; k++) begin
        e2_c_q[k]   <= (e1_mode_q == MODE_DIVERGENT) ? acc_t'(blend[k][32:16]) : e1_c_q[k];
        e2_acc_q[k] <= turbo_step(e1_acc_q[k], e1_t_q, k, 3);
      end
    end
  end

  // e3: hue mix
  logic                      e3_v_q;
  map_mode_e                 e3_mode_q;
  acc_t                      e3_c_q [3];
  acc_t                      e3_acc_q [3];
  q16_t                      e3_t_q;
  logic [2:0][FRAC_BITS+1:0] hue_mix;

  assign hue_mix = hsv_mix(e2_sec_q, e2_ch_q, e2_xx_q, e2_m_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_mode_q <= e2_mode_q;
      e3_t_q    <= e2_t_q;
      for (int k = 0; k < 3; k++) begin
        e3_c_q[k]   <= (e2_mode_q == MODE_HUE) ? acc_t'(hue_mix[k]) : e2_c_q[k];
        e3_acc_q[k] <= turbo_step(e2_acc_q[k], e2_t_q, k, 2);
      end
    end
  end

  // e4
  logic      e4_v_q;
  map_mode_e e4_mode_q;
  acc_t      e4_c_q [3];
  acc_t      e4_acc_q [3];
  q16_t      e4_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e4_mode_q <= e3_mode_q;
      e4_t_q    <= e3_t_q;
      for (int k = 0; k < 3; k++) begin
        e4_c_q[k]   <= e3_c_q[k];
        e4_acc_q[k] <= turbo_step(e3_acc_q[k], e3_t_q, k, 1);
      end
    end
  end

  // e5: last turbo step
  logic e5_v_q;
  acc_t e5_c_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e5_c_q[k] <= (e4_mode_q == MODE_TURBO) ? turbo_step(e4_acc_q[k], e4_t_q, k, 0)
                                               : e4_c_q[k];
      end
    end
  end

  // output scaling
  function automatic logic [COLOR_BITS-1:0] to_out(acc_t c);
    q16_t                          cl;
    logic [FRAC_BITS+COLOR_BITS:0] p;
    if (c < 0) begin
      cl = '0;
    end else if (c > acc_t'(ONE_Q16)) begin
      cl = ONE_Q16;
    end else begin
      cl = c[FRAC_BITS:0];
    end
    p = (FRAC_BITS+COLOR_BITS+1)'(cl) * (FRAC_BITS+COLOR_BITS+1)'(MAXC)
        + (FRAC_BITS+COLOR_BITS+1)'(32768);
    return p[FRAC_BITS+COLOR_BITS-1:FRAC_BITS];
  endfunction

  logic [COLOR_BITS-1:0] out_r_q, out_g_q, out_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_r_q <= to_out(e5_c_q[0]);
      out_g_q <= to_out(e5_c_q[1]);
      out_b_q <= to_out(e5_c_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_v_q  <= 1'b0;
      e1_v_q  <= 1'b0;
      e2_v_q  <= 1'b0;
      e3_v_q  <= 1'b0;
      e4_v_q  <= 1'b0;
      e5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      e0_v_q  <= div_v;
      e1_v_q  <= e0_v_q;
      e2_v_q  <= e1_v_q;
      e3_v_q  <= e2_v_q;
      e4_v_q  <= e3_v_q;
      e5_v_q  <= e4_v_q;
      out_v_q <= e5_v_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_W'({out_b_q, out_g_q, out_r_q});

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("pipeline advances while output is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e0_v_q |-> (e0_t_q <= ONE_Q16) && (e0_u_q <= ONE_Q16))
    else $error("normalized fraction exceeds one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e5_v_q && en) |=> out_v_q)
    else $error("result lost before output register");
`endif

endmodule
